FILE: rtl/srtl_pkg.sv
// Shared constants, codes and types of the sorted range table lookup.
`timescale 1ns / 1ps
package srtl_pkg;

	localparam int DEF_TABLE_DEPTH = 65536;
	localparam int DEF_PROBE_LIMIT = 30;

	localparam int IDX_W  = 16;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 17;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_PROBE,
		ST_CHECK
	} srtl_state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} tbl_ctl_t;

endpackage

FILE: rtl/srtl_ifs.sv
// Valid/ready channel interfaces for the request and response beats.
`timescale 1ns / 1ps
interface srtl_req_if import srtl_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [IDX_W-1:0]         entry_index;
	logic [WORD_W-1:0]        range_start;
	logic signed [WORD_W-1:0] latitude_word;
	logic signed [WORD_W-1:0] longitude_word;
	logic [WORD_W-1:0]        search_key;

	modport source (
		output valid, opcode, entry_index, range_start, latitude_word, longitude_word,
			search_key,
		input ready
	);
	modport sink (
		input valid, opcode, entry_index, range_start, latitude_word, longitude_word,
			search_key,
		output ready
	);
endinterface

interface srtl_rsp_if import srtl_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic [IDX_W-1:0]         found_index;
	logic signed [WORD_W-1:0] found_latitude;
	logic signed [WORD_W-1:0] found_longitude;

	modport source (
		output valid, hit, found_index, found_latitude, found_longitude,
		input ready
	);
	modport sink (
		input valid, hit, found_index, found_latitude, found_longitude,
		output ready
	);
endinterface

FILE: rtl/srtl_table.sv
// Table memories: start addresses (two read ports) and the two carried words.
`timescale 1ns / 1ps
module srtl_table import srtl_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                     clk,
	input  tbl_ctl_t                 ctl,
	input  logic [AW-1:0]            wr_addr,
	input  logic [WORD_W-1:0]        wr_start,
	input  logic signed [WORD_W-1:0] wr_lat,
	input  logic signed [WORD_W-1:0] wr_lon,
	input  logic [AW-1:0]            addr_a,
	input  logic [AW-1:0]            addr_b,
	output logic [WORD_W-1:0]        start_a,
	output logic [WORD_W-1:0]        start_b,
	output logic signed [WORD_W-1:0] lat_a,
	output logic signed [WORD_W-1:0] lon_a
);

	logic [WORD_W-1:0]        start_mem [TABLE_DEPTH];
	logic signed [WORD_W-1:0] lat_mem   [TABLE_DEPTH];
	logic signed [WORD_W-1:0] lon_mem   [TABLE_DEPTH];

	logic [WORD_W-1:0]        start_a_q;
	logic [WORD_W-1:0]        start_b_q;
	logic signed [WORD_W-1:0] lat_a_q;
	logic signed [WORD_W-1:0] lon_a_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			start_mem[wr_addr] <= wr_start;
			lat_mem[wr_addr]   <= wr_lat;
			lon_mem[wr_addr]   <= wr_lon;
		end
	end

	// port A serves middle (and carried words), port B the entry after it
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			start_a_q <= start_mem[addr_a];
			start_b_q <= start_mem[addr_b];
			lat_a_q   <= lat_mem[addr_a];
			lon_a_q   <= lon_mem[addr_a];
		end
	end

	assign start_a = start_a_q;
	assign start_b = start_b_q;
	assign lat_a   = lat_a_q;
	assign lon_a   = lon_a_q;

endmodule

FILE: rtl/srtl_ctrl.sv
// Bisection sequencer: probe addressing, range compare, output register.
`timescale 1ns / 1ps
module srtl_ctrl import srtl_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int PROBE_LIMIT = DEF_PROBE_LIMIT,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	srtl_req_if.sink                 req,
	srtl_rsp_if.source               rsp,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_wdata,
	output tbl_ctl_t                 ctl,
	output logic [AW-1:0]            wr_addr,
	output logic [AW-1:0]            addr_a,
	output logic [AW-1:0]            addr_b,
	input  logic [WORD_W-1:0]        start_a,
	input  logic [WORD_W-1:0]        start_b,
	input  logic signed [WORD_W-1:0] lat_a,
	input  logic signed [WORD_W-1:0] lon_a
);

	localparam int PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam logic [PW-1:0] LAST_PROBE = PW'(PROBE_LIMIT - 1);

	srtl_state_t state_q, state_d;

	logic [AW-1:0]     high_init_q, high_init_d;
	logic [AW-1:0]     low_q, low_d;
	logic [AW-1:0]     high_q, high_d;
	logic [AW-1:0]     mid_q, mid_d;
	logic [WORD_W-1:0] key_q, key_d;
	logic [WORD_W-1:0] s_high_q, s_high_d;
	logic [PW-1:0]     probe_q, probe_d;

	logic                     out_valid_q;
	logic                     out_load;
	logic                     out_hit_d, out_hit_q;
	logic [IDX_W-1:0]         out_idx_d, out_idx_q;
	logic signed [WORD_W-1:0] out_lat_d, out_lat_q;
	logic signed [WORD_W-1:0] out_lon_d, out_lon_q;

	logic [AW:0]       sum_c;
	logic [AW-1:0]     mid_c;
	logic [AW:0]       nxt_w;
	logic [AW-1:0]     nxt_c;
	logic [31:0]       idx_ext;
	logic              idx_ok;
	logic              ge_mid, lt_next, le_high, found, last;

	// clamp the entry count to [2, TABLE_DEPTH] once, at the write
	always_comb begin
		if (cfg_wdata < CNT_W'(2)) begin
			high_init_d = AW'(1);
		end else if (32'(cfg_wdata) > 32'(TABLE_DEPTH)) begin
			high_init_d = AW'(TABLE_DEPTH - 1);
		end else begin
			high_init_d = AW'(32'(cfg_wdata) - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_init_q <= AW'(1);
		end else if (cfg_we) begin
			high_init_q <= high_init_d;
		end
	end

	assign sum_c   = {1'b0, low_q} + {1'b0, high_q};
	assign mid_c   = sum_c[AW:1];
	assign nxt_w   = {1'b0, mid_c} + (AW+1)'(1);
	assign nxt_c   = (nxt_w == (AW+1)'(TABLE_DEPTH)) ? mid_c : nxt_w[AW-1:0];
	assign idx_ext = {16'b0, req.entry_index};
	assign idx_ok  = (idx_ext < 32'(TABLE_DEPTH));
	assign wr_addr = AW'(idx_ext);

	assign ge_mid  = (key_q >= start_a);
	assign lt_next = (key_q < start_b);
	assign le_high = (key_q <= s_high_q);
	assign found   = ge_mid && lt_next;
	assign last    = (probe_q == LAST_PROBE);

	always_comb begin
		state_d   = state_q;
		low_d     = low_q;
		high_d    = high_q;
		mid_d     = mid_q;
		key_d     = key_q;
		s_high_d  = s_high_q;
		probe_d   = probe_q;
		ctl       = '0;
		addr_a    = mid_c;
		addr_b    = nxt_c;
		req.ready = 1'b0;
		out_load  = 1'b0;
		out_hit_d = 1'b0;
		out_idx_d = '0;
		out_lat_d = '0;
		out_lon_d = '0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.opcode == OP_LOAD) begin
						ctl.wr_en = idx_ok;
					end else begin
						// fetch start[high] ahead of the first probe
						ctl.rd_en = 1'b1;
						addr_a    = high_init_q;
						key_d     = req.search_key;
						low_d     = '0;
						high_d    = high_init_q;
						probe_d   = '0;
						state_d   = ST_SEED;
					end
				end
			end
			ST_SEED: begin
				s_high_d  = start_a;
				ctl.rd_en = 1'b1;
				mid_d     = mid_c;
				state_d   = ST_CHECK;
			end
			ST_PROBE: begin
				ctl.rd_en = 1'b1;
				mid_d     = mid_c;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (found || last) begin
					if (!out_valid_q || rsp.ready) begin
						out_load = 1'b1;
						if (found) begin
							out_hit_d = 1'b1;
							out_idx_d = IDX_W'(mid_q);
							out_lat_d = lat_a;
							out_lon_d = lon_a;
						end
						state_d = ST_IDLE;
					end
				end else begin
					probe_d = probe_q + PW'(1);
					if (ge_mid && le_high) begin
						low_d = mid_q;
					end else begin
						high_d   = mid_q;
						s_high_d = start_a;
					end
					state_d = ST_PROBE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		low_q    <= low_d;
		high_q   <= high_d;
		mid_q    <= mid_d;
		key_q    <= key_d;
		s_high_q <= s_high_d;
		probe_q  <= probe_d;
		if (out_load) begin
			out_hit_q <= out_hit_d;
			out_idx_q <= out_idx_d;
			out_lat_q <= out_lat_d;
			out_lon_q <= out_lon_d;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.hit             = out_hit_q;
	assign rsp.found_index     = out_idx_q;
	assign rsp.found_latitude  = out_lat_q;
	assign rsp.found_longitude = out_lon_q;

	a_rise_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CHECK))
		else $error("response appeared outside a check cycle");

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE || state_q == ST_CHECK) |-> (low_q <= high_q))
		else $error("bisection bounds crossed");

	a_mid_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (mid_q >= low_q && mid_q <= high_q))
		else $error("probe index outside bounds");

	a_probe_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (probe_q <= LAST_PROBE))
		else $error("probe count past limit");

	a_no_read_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> !ctl.rd_en)
		else $error("table write and read in the same cycle");

endmodule

FILE: rtl/sorted_range_table_lookup_top.sv
// Top level of the sorted range table lookup: sequencer plus table memories.
// Load beat: written at the accepting edge, no response; loads go back to back.
// Query beat: p probes (1 <= p <= PROBE_LIMIT); the last check registers the
//   response, waiting while one is still pending; the next request is taken
//   the cycle after it registers. Each probe: two-port start read, then compare.
// Reset: state machine idle, no response pending, entry count 2; memories keep
//   whatever they hold and need no clearing pass.
`timescale 1ns / 1ps
module sorted_range_table_lookup_top import srtl_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int PROBE_LIMIT = DEF_PROBE_LIMIT
) (
	input  logic             clk,
	input  logic             arst_n,
	srtl_req_if.sink         req,
	srtl_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	// table address width; entry_index is zero-extended and range checked
	localparam int AW = $clog2(TABLE_DEPTH);

	tbl_ctl_t                 ctl;
	logic [AW-1:0]            wr_addr;
	logic [AW-1:0]            addr_a;
	logic [AW-1:0]            addr_b;
	logic [WORD_W-1:0]        start_a;
	logic [WORD_W-1:0]        start_b;
	logic signed [WORD_W-1:0] lat_a;
	logic signed [WORD_W-1:0] lon_a;

	// Sequencer: takes request beats, walks the bisection, holds the response
	// register so a finished result can wait while the table sits idle.
	srtl_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PROBE_LIMIT (PROBE_LIMIT),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.wr_addr   (wr_addr),
		.addr_a    (addr_a),
		.addr_b    (addr_b),
		.start_a   (start_a),
		.start_b   (start_b),
		.lat_a     (lat_a),
		.lon_a     (lon_a)
	);

	// Table: load data comes straight from the request beat; port A reads the
	// middle entry with its carried words, port B the entry that bounds it.
	srtl_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_table (
		.clk      (clk),
		.ctl      (ctl),
		.wr_addr  (wr_addr),
		.wr_start (req.range_start),
		.wr_lat   (req.latitude_word),
		.wr_lon   (req.longitude_word),
		.addr_a   (addr_a),
		.addr_b   (addr_b),
		.start_a  (start_a),
		.start_b  (start_b),
		.lat_a    (lat_a),
		.lon_a    (lon_a)
	);

endmodule
